// ===== sv/credential_id_table_macros.svh =====
// Assertion macros for the credential identifier table.
`ifndef CREDENTIAL_ID_TABLE_MACROS_SVH
`define CREDENTIAL_ID_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside reset.
`define CIT_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("credential_id_table: invariant violated");

// The consequent holds in the cycle after the antecedent.
`define CIT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("credential_id_table: sequence violated");

`else

`define CIT_ASSERT_ALWAYS(name, clk, rst, expr)
`define CIT_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== sv/cit_pkg.sv =====
// Shared types and constants of the credential identifier table.
`default_nettype none

package cit_pkg;

   // Fixed widths of the transfer fields.
   localparam int ID_LOW_WIDTH    = 64;
   localparam int ID_HIGH_WIDTH   = 16;
   localparam int ID_FULL_WIDTH   = ID_LOW_WIDTH + ID_HIGH_WIDTH;
   localparam int LENGTH_WIDTH    = 4;
   localparam int COUNT_OUT_WIDTH = 5;
   localparam int BYTE_WIDTH      = 8;

   // Operation codes carried by a request.
   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_FIND   = 2'd1,
      KIND_REMOVE = 2'd2
   } kind_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic do_add;
      logic do_remove;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/cit_cell.sv =====
// One table cell: holds an entry, compares it with the query and shifts on removal.
`default_nettype none

module cit_cell #(
   parameter int ID_BYTES = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire cit_pkg::cell_ctrl_type              ctrl,
   input  wire logic [ID_BYTES*cit_pkg::BYTE_WIDTH-1:0] query_id,
   input  wire logic [cit_pkg::LENGTH_WIDTH-1:0]    query_length,
   input  wire logic                                below_valid,
   input  wire logic                                below_hit,
   input  wire logic                                above_valid,
   input  wire logic [ID_BYTES*cit_pkg::BYTE_WIDTH-1:0] above_id,
   input  wire logic [cit_pkg::LENGTH_WIDTH-1:0]    above_length,
   output logic                                     valid,
   output logic [ID_BYTES*cit_pkg::BYTE_WIDTH-1:0]  id,
   output logic [cit_pkg::LENGTH_WIDTH-1:0]         length,
   output logic                                     hit_out
);

   localparam int IdWidth = ID_BYTES * cit_pkg::BYTE_WIDTH;

   logic                             valid_ff, valid_in;
   logic [IdWidth-1:0]               id_ff, id_in;
   logic [cit_pkg::LENGTH_WIDTH-1:0] length_ff, length_in;
   logic                             prefix_match;
   logic                             hit;
   logic                             take_new;
   logic                             take_above;

   // Compare the leading query-length bytes; later bytes are ignored.
   always_comb begin
      prefix_match = 1'b1;
      for (int b = 0; b < ID_BYTES; b++) begin
         if ((b < int'(query_length)) &&
             (id_ff[b*cit_pkg::BYTE_WIDTH +: cit_pkg::BYTE_WIDTH] !=
              query_id[b*cit_pkg::BYTE_WIDTH +: cit_pkg::BYTE_WIDTH])) begin
            prefix_match = 1'b0;
         end
      end
   end

   assign hit     = valid_ff && prefix_match;
   assign hit_out = below_hit || hit;

   // The first free cell takes a new entry; cells at or above the first hit shift down.
   assign take_new   = ctrl.do_add && !valid_ff && below_valid;
   assign take_above = ctrl.do_remove && valid_ff && (below_hit || hit);

   always_comb begin
      valid_in  = valid_ff;
      id_in     = id_ff;
      length_in = length_ff;
      if (take_new) begin
         valid_in  = 1'b1;
         id_in     = query_id;
         length_in = query_length;
      end else if (take_above) begin
         valid_in  = above_valid;
         id_in     = above_id;
         length_in = above_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Entry contents are only ever read while the cell is valid.
   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      length_ff <= length_in;
   end

   assign valid  = valid_ff;
   assign id     = id_ff;
   assign length = length_ff;

endmodule

`default_nettype wire

// ===== sv/credential_id_table.sv =====
// Top level of the credential identifier table: a chain of compare-and-shift cells.
//
//   Channel   Direction  Handshake                Contents
//   req_      in         req_valid / req_ready    kind, identifier bytes, length
//   rsp_      out        rsp_valid / rsp_ready    ok flag, entry count
//
// One request is taken per cycle while req_ready is high; every cell compares and shifts in the same cycle.
// The result appears in the output register in the cycle after the request transfer.
// A new request is taken while the output register is empty or being emptied.
// Reset clears all valid bits and the count at once; no clearing pass is needed.
// A stalled result holds the request side until it is taken.
`default_nettype none

`include "credential_id_table_macros.svh"

module credential_id_table #(
   parameter int MAX_ENTRIES = 16,
   parameter int ID_BYTES    = 10
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [1:0]                            req_kind,
   input  wire logic [cit_pkg::ID_LOW_WIDTH-1:0]      req_id_bytes_low,
   input  wire logic [cit_pkg::ID_HIGH_WIDTH-1:0]     req_id_bytes_high,
   input  wire logic [cit_pkg::LENGTH_WIDTH-1:0]      req_id_length,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_ok,
   output logic [cit_pkg::COUNT_OUT_WIDTH-1:0]        rsp_entry_count
);

   localparam int IdWidth    = ID_BYTES * cit_pkg::BYTE_WIDTH;
   localparam int CountWidth = $clog2(MAX_ENTRIES + 1);

   logic                                  accept;
   logic [cit_pkg::ID_FULL_WIDTH-1:0]     query_full;
   logic [IdWidth-1:0]                    query_id;
   logic [cit_pkg::LENGTH_WIDTH-1:0]      query_length;
   cit_pkg::cell_ctrl_type                ctrl;

   logic [MAX_ENTRIES-1:0]                valid_vec;
   logic [MAX_ENTRIES-1:0]                hit_vec;
   logic [IdWidth-1:0]                    id_vec     [MAX_ENTRIES];
   logic [cit_pkg::LENGTH_WIDTH-1:0]      length_vec [MAX_ENTRIES];
   logic                                  any_hit;

   logic [CountWidth-1:0]                 count_ff, count_in;
   logic [CountWidth-1:0]                 count_next;
   logic                                  result_ok;
   logic [31:0]                           count_wide;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  rsp_ok_ff;
   logic [cit_pkg::COUNT_OUT_WIDTH-1:0]   rsp_entry_count_ff;

   // Request transfer: the output register parts the two sides.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Query bytes above the configured identifier size are dropped.
   assign query_full = {req_id_bytes_high, req_id_bytes_low};
   assign query_id   = query_full[IdWidth-1:0];

   // Lengths beyond the identifier size saturate.
   assign query_length = (req_id_length > cit_pkg::LENGTH_WIDTH'(ID_BYTES)) ?
                         cit_pkg::LENGTH_WIDTH'(ID_BYTES) : req_id_length;

   assign ctrl.do_add    = accept && (req_kind == cit_pkg::KIND_ADD);
   assign ctrl.do_remove = accept && (req_kind == cit_pkg::KIND_REMOVE);

   // Chain of cells; the hit flag ripples upwards, entries shift downwards.
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic                             below_valid;
      logic                             below_hit;
      logic                             above_valid;
      logic [IdWidth-1:0]               above_id;
      logic [cit_pkg::LENGTH_WIDTH-1:0] above_length;

      if (i == 0) begin : g_first
         assign below_valid = 1'b1;
         assign below_hit   = 1'b0;
      end else begin : g_inner_below
         assign below_valid = valid_vec[i-1];
         assign below_hit   = hit_vec[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_last
         assign above_valid  = 1'b0;
         assign above_id     = '0;
         assign above_length = '0;
      end else begin : g_inner_above
         assign above_valid  = valid_vec[i+1];
         assign above_id     = id_vec[i+1];
         assign above_length = length_vec[i+1];
      end

      cit_cell #(
         .ID_BYTES (ID_BYTES)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .query_id     (query_id),
         .query_length (query_length),
         .below_valid  (below_valid),
         .below_hit    (below_hit),
         .above_valid  (above_valid),
         .above_id     (above_id),
         .above_length (above_length),
         .valid        (valid_vec[i]),
         .id           (id_vec[i]),
         .length       (length_vec[i]),
         .hit_out      (hit_vec[i])
      );
   end

   assign any_hit = hit_vec[MAX_ENTRIES-1];

   // Outcome of the operation and the resulting entry count.
   always_comb begin
      result_ok  = 1'b0;
      count_next = count_ff;
      case (req_kind)
         cit_pkg::KIND_ADD: begin
            if (count_ff < CountWidth'(MAX_ENTRIES)) begin
               result_ok  = 1'b1;
               count_next = count_ff + CountWidth'(1);
            end
         end
         cit_pkg::KIND_FIND: begin
            result_ok = any_hit;
         end
         cit_pkg::KIND_REMOVE: begin
            if (any_hit) begin
               result_ok  = 1'b1;
               count_next = count_ff - CountWidth'(1);
            end
         end
         default: begin
            result_ok = 1'b0;
         end
      endcase
   end

   assign count_in   = accept ? count_next : count_ff;
   assign count_wide = 32'(count_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Output register: loaded on a request transfer, held while stalled.
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff          <= result_ok;
         rsp_entry_count_ff <= count_wide[cit_pkg::COUNT_OUT_WIDTH-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   // The table never holds more entries than it has cells.
   `CIT_ASSERT_ALWAYS(a_count_bounded, clock, reset, count_ff <= CountWidth'(MAX_ENTRIES))

   // The valid cells always agree with the entry count.
   `CIT_ASSERT_ALWAYS(a_valid_matches_count, clock, reset, $countones(valid_vec) == int'(count_ff))

   // An add into a table with room always reports success.
   `CIT_ASSERT_NEXT(a_add_succeeds, clock, reset, ctrl.do_add && (count_ff < CountWidth'(MAX_ENTRIES)), rsp_valid && rsp_ok)

   // A removal from an empty table always fails and leaves it empty.
   `CIT_ASSERT_NEXT(a_remove_empty_fails, clock, reset, ctrl.do_remove && (count_ff == '0), !rsp_ok && (count_ff == '0))

endmodule

`default_nettype wire
